FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the PCM stream parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/wpsp_pkg.sv
// ----------------------------------------------------------------------------
// wpsp_pkg
// Constants and codes shared by the PCM stream parser modules.
// ----------------------------------------------------------------------------
package wpsp_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 18;

    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_SHORT  = 2'd0;
    localparam logic [1:0] ERR_SIZE   = 2'd1;
    localparam logic [1:0] ERR_FORMAT = 2'd2;
    localparam logic [1:0] ERR_BITS   = 2'd3;

    localparam logic [31:0] DATA_ID      = 32'h6461_7461;
    localparam logic [31:0] HEADER_BYTES = 32'd36;
    localparam logic [31:0] RIFF_PREFIX  = 32'd8;
    localparam logic [15:0] PCM_FORMAT   = 16'd1;
    localparam logic [15:0] BITS_16      = 16'd16;
    localparam logic [15:0] BITS_24      = 16'd24;

endpackage

FILE: rtl/wpsp_in_if.sv
// ----------------------------------------------------------------------------
// wpsp_in_if
// Byte channel into the parser: one file byte and a start-of-file mark.
// ----------------------------------------------------------------------------
interface wpsp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink   (input valid, input data_byte, input file_start, output ready);

endinterface

FILE: rtl/wpsp_out_if.sv
// ----------------------------------------------------------------------------
// wpsp_out_if
// Result channel of the parser: format report, sample or error word.
// ----------------------------------------------------------------------------
interface wpsp_out_if;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [23:0] sample_value;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        frame_count;
    logic               last_sample;
    logic [1:0]         error_code;

    modport source (
        output valid, output kind, output sample_value, output channel_count,
        output sample_rate, output byte_rate, output block_align,
        output bits_per_sample, output frame_count, output last_sample,
        output error_code, input ready
    );
    modport sink (
        input valid, input kind, input sample_value, input channel_count,
        input sample_rate, input byte_rate, input block_align,
        input bits_per_sample, input frame_count, input last_sample,
        input error_code, output ready
    );

endinterface

FILE: rtl/wpsp_div.sv
// ----------------------------------------------------------------------------
// wpsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpsp_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [wpsp_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [wpsp_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [wpsp_pkg::DIVIDEND_W-1:0]     o_quotient
);

    localparam int QW  = wpsp_pkg::DIVIDEND_W;
    localparam int DW  = wpsp_pkg::DIVISOR_W;
    localparam int CW  = $clog2(QW);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [QW-1:0]   r_quot;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;

    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_quot[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quot  <= i_dividend;
                        r_rem   <= '0;
                        r_div   <= i_divisor;
                        r_count <= CW'(QW - 1);
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem   <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_quot  <= {r_quot[QW-2:0], w_ge};
                    r_count <= r_count - 1'b1;
                    if (r_count == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done     = (r_state == ST_DONE);
    assign o_quotient = r_quot;

    `ASSERT_IMPL(a_start_when_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE)
    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == ST_RUN, r_rem < r_div)

endmodule

FILE: rtl/wpsp_scale.sv
// ----------------------------------------------------------------------------
// wpsp_scale
// Scales a 16-bit sample to Q1.23 by 2^23/32767 with rounding and saturation.
// ----------------------------------------------------------------------------
module wpsp_scale (
    input  logic [15:0]        i_raw,
    output logic signed [23:0] o_q
);

    localparam logic [16:0] HALF_DEN = 17'd32767;
    localparam logic [16:0] FULL_DEN = 17'd65534;
    localparam logic [24:0] Q_MAX    = 25'd8388607;
    localparam logic [24:0] Q_ONE    = 25'd8388608;

    logic        w_neg;
    logic [15:0] w_mag;
    logic [8:0]  w_k;
    logic [6:0]  w_m;
    logic [16:0] w_t;
    logic        w_round;
    logic [8:0]  w_r;
    logic [24:0] w_q;
    logic [24:0] w_negq;

    // With a = 128k + m, round(256a / 32767) is k plus one when the leftover
    // reaches half the denominator.
    assign w_neg   = i_raw[15];
    assign w_mag   = w_neg ? (~i_raw + 16'd1) : i_raw;
    assign w_k     = w_mag[15:7];
    assign w_m     = w_mag[6:0];
    assign w_t     = {7'd0, w_k, 1'b0} + {1'b0, w_m, 9'd0} + HALF_DEN;
    assign w_round = w_t >= FULL_DEN;
    assign w_r     = w_k + {8'd0, w_round};
    assign w_q     = {1'b0, w_mag, 8'd0} + {16'd0, w_r};
    assign w_negq  = 25'd0 - w_q;

    always_comb begin
        if (!w_neg) begin
            o_q = (w_q > Q_MAX) ? 24'sh7F_FFFF : $signed(w_q[23:0]);
        end else begin
            o_q = (w_q >= Q_ONE) ? 24'sh80_0000 : $signed(w_negq[23:0]);
        end
    end

endmodule

FILE: rtl/wave_pcm_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// wave_pcm_stream_parser_unit
// Byte-serial WAVE PCM parser. It takes one file byte per cycle through the
// header, format and chunk-skip phases and through the sample data, giving a
// result word for each finished sample, the format report and any error.
// When the data chunk header completes, the frame count is worked out by a
// bit-serial divider; the input is held off through its 32 steps, the multiply
// and the report, once per file. Each word is held in an output register;
// the next byte is taken in the cycle that register is free or being emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wave_pcm_stream_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    wpsp_in_if.sink      i_in,
    wpsp_out_if.source   o_out
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_HEAD, PH_FMT, PH_CID, PH_CSIZE, PH_SKIP,
        PH_SAMP, PH_HALT, PH_DIV, PH_MUL, PH_RPT
    } t_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] sample_value;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [31:0]        byte_rate;
        logic [15:0]        block_align;
        logic [15:0]        bits_per_sample;
        logic [31:0]        frame_count;
        logic               last_sample;
        logic [1:0]         error_code;
    } t_result;

    t_phase        r_phase,      n_phase;
    logic [4:0]    r_pos,        n_pos;
    logic [31:0]   r_file_length;
    logic [31:0]   r_shift,      n_shift;
    logic [31:0]   r_cid,        n_cid;
    logic [31:0]   r_skip,       n_skip;
    logic [31:0]   r_samples,    n_samples;
    logic [15:0]   r_channels,   n_channels;
    logic [31:0]   r_rate,       n_rate;
    logic [31:0]   r_byte_rate,  n_byte_rate;
    logic [15:0]   r_align,      n_align;
    logic [15:0]   r_bits,       n_bits;
    logic [23:0]   r_asm,        n_asm;
    logic [31:0]   r_frames,     n_frames;
    logic          r_out_valid,  n_out_valid;
    t_result       r_res,        n_res;

    logic          w_accept;
    logic          w_busy;
    logic          w_too_short;
    t_phase        w_ph;
    logic [4:0]    w_p;
    logic [31:0]   w_shift_in;
    logic [23:0]   w_asm_in;
    logic          w_wide;
    logic [17:0]   w_frame_bytes;
    logic          w_div_start;
    logic          w_div_done;
    logic [31:0]   w_quot;
    logic [47:0]   w_prod;
    logic signed [23:0] w_scaled;

    assign w_busy      = (r_phase == PH_DIV) || (r_phase == PH_MUL) || (r_phase == PH_RPT);
    assign i_in.ready  = !w_busy && (!r_out_valid || o_out.ready);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_too_short = r_file_length <= wpsp_pkg::HEADER_BYTES;
    assign w_ph        = i_in.file_start ? PH_HEAD : r_phase;
    assign w_p         = i_in.file_start ? 5'd0 : r_pos;
    assign w_shift_in  = {i_in.data_byte, r_shift[31:8]};
    assign w_asm_in    = {i_in.data_byte, r_asm[23:8]};
    assign w_wide      = (r_bits == wpsp_pkg::BITS_24);
    assign w_frame_bytes = {1'b0, r_channels, 1'b0} + (w_wide ? {2'b0, r_channels} : 18'd0);
    assign w_prod      = r_frames * r_channels;

    wpsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_shift_in),
        .i_divisor  (w_frame_bytes),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    wpsp_scale u_scale (
        .i_raw (w_asm_in[23:8]),
        .o_q   (w_scaled)
    );

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_cid       = r_cid;
        n_skip      = r_skip;
        n_samples   = r_samples;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_byte_rate = r_byte_rate;
        n_align     = r_align;
        n_bits      = r_bits;
        n_asm       = r_asm;
        n_frames    = r_frames;
        n_out_valid = r_out_valid && !o_out.ready;
        n_res       = r_res;
        w_div_start = 1'b0;

        if (w_accept) begin
            if (i_in.file_start && w_too_short) begin
                n_res            = '0;
                n_res.kind       = wpsp_pkg::KIND_ERROR;
                n_res.error_code = wpsp_pkg::ERR_SHORT;
                n_out_valid      = 1'b1;
                n_phase          = PH_HALT;
                n_pos            = 5'd0;
            end else begin
                n_phase = w_ph;
                n_pos   = w_p;
                case (w_ph)
                    PH_HEAD: begin
                        n_shift = w_shift_in;
                        if (w_p == 5'd7 &&
                            w_shift_in != r_file_length - wpsp_pkg::RIFF_PREFIX) begin
                            n_res            = '0;
                            n_res.kind       = wpsp_pkg::KIND_ERROR;
                            n_res.error_code = wpsp_pkg::ERR_SIZE;
                            n_out_valid      = 1'b1;
                            n_phase          = PH_HALT;
                        end else if (w_p >= 5'd11) begin
                            n_phase = PH_FMT;
                            n_pos   = 5'd0;
                        end else begin
                            n_pos = w_p + 5'd1;
                        end
                    end
                    PH_FMT: begin
                        n_shift = w_shift_in;
                        n_pos   = w_p + 5'd1;
                        if (w_p == 5'd11) n_channels  = w_shift_in[31:16];
                        if (w_p == 5'd15) n_rate      = w_shift_in;
                        if (w_p == 5'd19) n_byte_rate = w_shift_in;
                        if (w_p == 5'd21) n_align     = w_shift_in[31:16];
                        if (w_p == 5'd9 && w_shift_in[31:16] != wpsp_pkg::PCM_FORMAT) begin
                            n_res            = '0;
                            n_res.kind       = wpsp_pkg::KIND_ERROR;
                            n_res.error_code = wpsp_pkg::ERR_FORMAT;
                            n_out_valid      = 1'b1;
                            n_phase          = PH_HALT;
                        end else if (w_p >= 5'd23) begin
                            n_bits = w_shift_in[31:16];
                            n_pos  = 5'd0;
                            if ((w_shift_in[31:16] != wpsp_pkg::BITS_16 &&
                                 w_shift_in[31:16] != wpsp_pkg::BITS_24) ||
                                r_channels == 16'd0) begin
                                n_res            = '0;
                                n_res.kind       = wpsp_pkg::KIND_ERROR;
                                n_res.error_code = wpsp_pkg::ERR_BITS;
                                n_out_valid      = 1'b1;
                                n_phase          = PH_HALT;
                            end else begin
                                n_phase = PH_CID;
                            end
                        end
                    end
                    PH_CID: begin
                        n_cid = {r_cid[23:0], i_in.data_byte};
                        if (w_p >= 5'd3) begin
                            n_phase = PH_CSIZE;
                            n_pos   = 5'd0;
                        end else begin
                            n_pos = w_p + 5'd1;
                        end
                    end
                    PH_CSIZE: begin
                        n_shift = w_shift_in;
                        if (w_p < 5'd3) begin
                            n_pos = w_p + 5'd1;
                        end else begin
                            n_pos = 5'd0;
                            if (r_cid == wpsp_pkg::DATA_ID) begin
                                w_div_start = 1'b1;
                                n_phase     = PH_DIV;
                            end else begin
                                n_skip  = w_shift_in;
                                n_phase = (w_shift_in != 32'd0) ? PH_SKIP : PH_CID;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 32'd1;
                        if (r_skip == 32'd1) begin
                            n_phase = PH_CID;
                            n_pos   = 5'd0;
                        end
                    end
                    PH_SAMP: begin
                        n_asm = w_asm_in;
                        if ((w_wide && w_p < 5'd2) || (!w_wide && w_p < 5'd1)) begin
                            n_pos = w_p + 5'd1;
                        end else begin
                            n_pos              = 5'd0;
                            n_samples          = r_samples - 32'd1;
                            n_res              = '0;
                            n_res.kind         = wpsp_pkg::KIND_SAMPLE;
                            n_res.sample_value = w_wide ? $signed(w_asm_in) : w_scaled;
                            n_res.last_sample  = (r_samples == 32'd1);
                            n_out_valid        = 1'b1;
                            if (r_samples == 32'd1) n_phase = PH_HALT;
                        end
                    end
                    default: begin
                        n_phase = w_ph;
                    end
                endcase
            end
        end else begin
            case (r_phase)
                PH_DIV: begin
                    if (w_div_done) begin
                        n_frames = w_quot;
                        n_phase  = PH_MUL;
                    end
                end
                PH_MUL: begin
                    n_samples = w_prod[31:0];
                    n_phase   = PH_RPT;
                end
                PH_RPT: begin
                    if (!r_out_valid || o_out.ready) begin
                        n_res                 = '0;
                        n_res.kind            = wpsp_pkg::KIND_REPORT;
                        n_res.channel_count   = r_channels;
                        n_res.sample_rate     = r_rate;
                        n_res.byte_rate       = r_byte_rate;
                        n_res.block_align     = r_align;
                        n_res.bits_per_sample = r_bits;
                        n_res.frame_count     = r_frames;
                        n_out_valid           = 1'b1;
                        n_phase               = (r_samples != 32'd0) ? PH_SAMP : PH_HALT;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_pos         <= 5'd0;
            r_out_valid   <= 1'b0;
            r_file_length <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_shift     <= n_shift;
            r_cid       <= n_cid;
            r_skip      <= n_skip;
            r_samples   <= n_samples;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_byte_rate <= n_byte_rate;
            r_align     <= n_align;
            r_bits      <= n_bits;
            r_asm       <= n_asm;
            r_frames    <= n_frames;
            r_res       <= n_res;
            if (i_cfg_wr_en) begin
                r_file_length <= i_cfg_wr_data;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_res.kind;
    assign o_out.sample_value    = r_res.sample_value;
    assign o_out.channel_count   = r_res.channel_count;
    assign o_out.sample_rate     = r_res.sample_rate;
    assign o_out.byte_rate       = r_res.byte_rate;
    assign o_out.block_align     = r_res.block_align;
    assign o_out.bits_per_sample = r_res.bits_per_sample;
    assign o_out.frame_count     = r_res.frame_count;
    assign o_out.last_sample     = r_res.last_sample;
    assign o_out.error_code      = r_res.error_code;

    `ASSERT_IMPL(a_hold_off_in_divide, i_clk, i_rst_n, w_busy, !i_in.ready)
    `ASSERT_IMPL(a_report_format_ok, i_clk, i_rst_n,
        r_out_valid && r_res.kind == wpsp_pkg::KIND_REPORT,
        r_res.channel_count != 16'd0 &&
        (r_res.bits_per_sample == wpsp_pkg::BITS_16 ||
         r_res.bits_per_sample == wpsp_pkg::BITS_24))
    `ASSERT_IMPL(a_last_only_on_sample, i_clk, i_rst_n,
        r_out_valid && r_res.last_sample, r_res.kind == wpsp_pkg::KIND_SAMPLE)

endmodule

FILE: tb/wave_pcm_stream_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_pcm_stream_parser_unit_tb
// Self-checking bench for the byte-serial WAVE PCM parser. A short table of
// header fragments covers the start-up behavior and the short-file and size
// errors. Random files follow: most are well formed with random fmt fields, extra chunks,
// sample data and trailing bytes, and the rest are short, corrupt, truncated
// or huge. A byte-level parser model predicts every result word, and each
// word from the block is compared with it field by field.
// ----------------------------------------------------------------------------
module wave_pcm_stream_parser_unit_tb;

    import wpsp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int BYTE_TARGET   = 1900;
    localparam int MAX_REPORTS   = 40;
    localparam longint Q23_MAX   = 64'sd8388607;
    localparam longint Q23_MIN   = -64'sd8388608;
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_LIST = 32'h5453_494C;

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_FORMAT, P_CHUNK_ID, P_CHUNK_SIZE, P_SKIP, P_SAMPLES, P_HALTED
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] sample_value;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] frame_count;
        logic        last_sample;
        logic [1:0]  error_code;
    } wave_word_t;

    typedef struct {
        bit          is_cfg;
        logic [31:0] value;
        logic        start;
        bit          typed;
        logic [1:0]  code;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    wpsp_in_if  in_ch ();
    wpsp_out_if out_ch ();

    wave_pcm_stream_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Parser model state.
    logic [31:0]  file_len_reg;
    parse_phase_e phase;
    logic [4:0]   byte_pos;
    logic [31:0]  le_shift;
    logic [31:0]  chunk_id;
    logic [31:0]  skip_left;
    logic [31:0]  samples_left;
    logic [15:0]  fmt_channels;
    logic [31:0]  fmt_rate;
    logic [31:0]  fmt_byte_rate;
    logic [15:0]  fmt_align;
    logic [15:0]  fmt_bits;
    logic [23:0]  sample_bytes;

    wave_word_t  expected_words[$];
    wave_word_t  typed_word;
    bit          typed_pending;
    dir_row_t    dir_rows[$];

    int unsigned mismatches;
    int unsigned cycles;
    int unsigned bytes_sent;
    int unsigned files_sent;
    int unsigned n_reports;
    int unsigned n_samples;
    int unsigned n_errors;
    int unsigned burst_left;
    int unsigned rx_tick;
    bit          gaps_on;
    logic [31:0] cur_len;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver cycles through always ready, random stalls and two
    // fixed stall patterns.
    always @(negedge i_clk) begin
        rx_tick++;
        case (rx_tick[8:7])
            2'd0:    out_ch.ready = 1'b1;
            2'd1:    out_ch.ready = 1'($urandom_range(0, 1));
            2'd2:    out_ch.ready = (rx_tick[1:0] == 2'd0);
            default: out_ch.ready = (rx_tick[2:0] != 3'd5);
        endcase
    end

    function automatic void clear_parser();
        phase         = P_IDLE;
        byte_pos      = '0;
        le_shift      = '0;
        chunk_id      = '0;
        skip_left     = '0;
        samples_left  = '0;
        fmt_channels  = '0;
        fmt_rate      = '0;
        fmt_byte_rate = '0;
        fmt_align     = '0;
        fmt_bits      = '0;
        sample_bytes  = '0;
    endfunction

    function automatic bit halt_with(input logic [1:0] code, output wave_word_t w);
        w            = '0;
        w.kind       = KIND_ERROR;
        w.error_code = code;
        phase        = P_HALTED;
        return 1'b1;
    endfunction

    function automatic logic [23:0] q23_from_16(input logic [15:0] raw);
        longint x;
        longint mag;
        longint q;
        x   = longint'($signed(raw));
        mag = (x < 0 ? -x : x) <<< 23;
        q   = (2 * mag + 32767) / 65534;
        if (x < 0) q = -q;
        if (q > Q23_MAX) q = Q23_MAX;
        if (q < Q23_MIN) q = Q23_MIN;
        return q[23:0];
    endfunction

    // Advances the model by one byte; returns 1 when the byte yields a word.
    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      output wave_word_t w);
        logic [31:0] frame_bytes;
        logic [31:0] frames;
        logic [15:0] need;
        logic [4:0]  pos;
        w = '0;
        if (start) begin
            clear_parser();
            if (file_len_reg <= HEADER_BYTES) return halt_with(ERR_SHORT, w);
            phase = P_HEADER;
        end
        pos = byte_pos;
        case (phase)
            P_HEADER: begin
                le_shift = {b, le_shift[31:8]};
                if (pos == 5'd7 && le_shift != file_len_reg - RIFF_PREFIX)
                    return halt_with(ERR_SIZE, w);
                if (pos >= 5'd11) begin
                    phase    = P_FORMAT;
                    byte_pos = '0;
                end else begin
                    byte_pos = pos + 5'd1;
                end
                return 1'b0;
            end
            P_FORMAT: begin
                le_shift = {b, le_shift[31:8]};
                byte_pos = pos + 5'd1;
                if (pos == 5'd9 && le_shift[31:16] != PCM_FORMAT)
                    return halt_with(ERR_FORMAT, w);
                if (pos == 5'd11) fmt_channels = le_shift[31:16];
                if (pos == 5'd15) fmt_rate = le_shift;
                if (pos == 5'd19) fmt_byte_rate = le_shift;
                if (pos == 5'd21) fmt_align = le_shift[31:16];
                if (pos >= 5'd23) begin
                    fmt_bits = le_shift[31:16];
                    if ((fmt_bits != BITS_16 && fmt_bits != BITS_24) || fmt_channels == 16'd0)
                        return halt_with(ERR_BITS, w);
                    phase    = P_CHUNK_ID;
                    byte_pos = '0;
                end
                return 1'b0;
            end
            P_CHUNK_ID: begin
                chunk_id = {chunk_id[23:0], b};
                if (pos >= 5'd3) begin
                    phase    = P_CHUNK_SIZE;
                    byte_pos = '0;
                end else begin
                    byte_pos = pos + 5'd1;
                end
                return 1'b0;
            end
            P_CHUNK_SIZE: begin
                le_shift = {b, le_shift[31:8]};
                if (pos < 5'd3) begin
                    byte_pos = pos + 5'd1;
                    return 1'b0;
                end
                byte_pos = '0;
                if (chunk_id == DATA_ID) begin
                    frame_bytes       = {16'd0, fmt_bits >> 3} * {16'd0, fmt_channels};
                    frames            = (frame_bytes != 0) ? le_shift / frame_bytes : 32'd0;
                    samples_left      = frames * {16'd0, fmt_channels};
                    sample_bytes      = '0;
                    phase             = (samples_left != 0) ? P_SAMPLES : P_HALTED;
                    w.kind            = KIND_REPORT;
                    w.channel_count   = fmt_channels;
                    w.sample_rate     = fmt_rate;
                    w.byte_rate       = fmt_byte_rate;
                    w.block_align     = fmt_align;
                    w.bits_per_sample = fmt_bits;
                    w.frame_count     = frames;
                    return 1'b1;
                end
                skip_left = le_shift;
                chunk_id  = '0;
                phase     = (skip_left != 0) ? P_SKIP : P_CHUNK_ID;
                return 1'b0;
            end
            P_SKIP: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 0) begin
                    phase    = P_CHUNK_ID;
                    chunk_id = '0;
                    byte_pos = '0;
                end
                return 1'b0;
            end
            P_SAMPLES: begin
                need         = fmt_bits >> 3;
                sample_bytes = {b, sample_bytes[23:8]};
                if (int'(pos) + 1 < int'(need)) begin
                    byte_pos = pos + 5'd1;
                    return 1'b0;
                end
                byte_pos       = '0;
                w.kind         = KIND_SAMPLE;
                w.sample_value = (need == 16'd2) ? q23_from_16(sample_bytes[23:8])
                                                 : sample_bytes;
                sample_bytes   = '0;
                samples_left   = samples_left - 32'd1;
                if (samples_left == 0) begin
                    w.last_sample = 1'b1;
                    phase         = P_HALTED;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    // Model update on each accepted byte, then the check of each accepted word.
    always @(posedge i_clk) begin
        wave_word_t predicted;
        wave_word_t got;
        wave_word_t want;
        bit         made;
        if (!i_rst_n) begin
            file_len_reg = '0;
            clear_parser();
        end else begin
            if (i_cfg_wr_en) file_len_reg = i_cfg_wr_data;
            if (in_ch.valid && in_ch.ready) begin
                made = parse_byte(in_ch.data_byte, in_ch.file_start, predicted);
                if (typed_pending) expected_words.push_back(typed_word);
                else if (made) expected_words.push_back(predicted);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.kind            = out_ch.kind;
                got.sample_value    = out_ch.sample_value;
                got.channel_count   = out_ch.channel_count;
                got.sample_rate     = out_ch.sample_rate;
                got.byte_rate       = out_ch.byte_rate;
                got.block_align     = out_ch.block_align;
                got.bits_per_sample = out_ch.bits_per_sample;
                got.frame_count     = out_ch.frame_count;
                got.last_sample     = out_ch.last_sample;
                got.error_code      = out_ch.error_code;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word of kind", got.kind, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.sample_value != want.sample_value)
                        report_mismatch("sample_value", got.sample_value, want.sample_value);
                    if (got.channel_count != want.channel_count)
                        report_mismatch("channel_count", got.channel_count, want.channel_count);
                    if (got.sample_rate != want.sample_rate)
                        report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
                    if (got.byte_rate != want.byte_rate)
                        report_mismatch("byte_rate", got.byte_rate, want.byte_rate);
                    if (got.block_align != want.block_align)
                        report_mismatch("block_align", got.block_align, want.block_align);
                    if (got.bits_per_sample != want.bits_per_sample)
                        report_mismatch("bits_per_sample", got.bits_per_sample,
                                        want.bits_per_sample);
                    if (got.frame_count != want.frame_count)
                        report_mismatch("frame_count", got.frame_count, want.frame_count);
                    if (got.last_sample != want.last_sample)
                        report_mismatch("last_sample", got.last_sample, want.last_sample);
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", got.error_code, want.error_code);
                    case (want.kind)
                        KIND_REPORT: n_reports++;
                        KIND_SAMPLE: n_samples++;
                        default:     n_errors++;
                    endcase
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (gaps_on && burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid      = 1'b1;
        in_ch.data_byte  = b;
        in_ch.file_start = start;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic settle();
        in_ch.valid = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [31:0] len);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = len;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        cur_len       = len;
    endtask

    task automatic put_le(ref logic [7:0] img[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
    endtask

    task automatic run_file();
        logic [7:0]  img[$];
        logic [31:0] len;
        logic [31:0] riff_size;
        logic [31:0] data_size;
        logic [31:0] word32;
        logic [31:0] data_le;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] fmt;
        int          roll;
        int          frames;
        int          frame_bytes;
        int          width;
        int          keep;
        int          k;
        bit          good;
        bit          huge;
        roll    = $urandom_range(0, 99);
        good    = (roll < 65);
        huge    = (roll >= 96);
        data_le = {<<8{DATA_ID}};
        bits    = $urandom_range(0, 1) ? BITS_16 : BITS_24;
        chans   = 16'($urandom_range(1, 3));
        fmt     = PCM_FORMAT;
        if (roll >= 76 && roll < 82)
            do fmt = 16'($urandom); while (fmt == PCM_FORMAT);
        if (roll >= 82 && roll < 87)
            do bits = $urandom_range(0, 1) ? 16'(8 * $urandom_range(0, 4)) : 16'($urandom);
            while (bits == BITS_16 || bits == BITS_24);
        if (roll >= 87 && roll < 91) chans = 16'd0;
        if (huge) chans = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(4, 65535));

        put_le(img, ID_RIFF, 4);
        put_le(img, 32'd0, 4);
        put_le(img, ID_WAVE, 4);
        put_le(img, ID_FMT, 4);
        put_le(img, $urandom_range(0, 1) ? 32'd16 : $urandom, 4);
        put_le(img, fmt, 2);
        put_le(img, chans, 2);
        put_le(img, $urandom, 4);
        put_le(img, $urandom, 4);
        put_le(img, $urandom, 2);
        put_le(img, bits, 2);

        repeat ($urandom_range(0, 2)) begin
            word32 = $urandom_range(0, 1) ? ID_LIST : $urandom;
            if (word32 == data_le) word32 ^= 32'd1;
            put_le(img, word32, 4);
            k = $urandom_range(0, 6);
            put_le(img, k, 4);
            repeat (k) img.push_back(8'($urandom));
        end

        width       = bits / 8;
        frame_bytes = width * chans;
        frames      = $urandom_range(0, 12);
        if (huge) data_size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        else data_size = frames * frame_bytes
                         + ((frame_bytes > 1) ? $urandom_range(0, frame_bytes - 1) : 0);
        put_le(img, data_le, 4);
        put_le(img, data_size, 4);
        if (huge) begin
            repeat (12) img.push_back(8'($urandom));
        end else if (good || roll >= 91) begin
            repeat (frames * chans) begin
                case ($urandom_range(0, 9))
                    0:       word32 = '0;
                    1:       word32 = '1;
                    2:       word32 = (bits == BITS_16) ? 32'h8000 : 32'h80_0000;
                    3:       word32 = (bits == BITS_16) ? 32'h7FFF : 32'h7F_FFFF;
                    4:       word32 = (bits == BITS_16) ? 32'h8001 : 32'h80_0001;
                    default: word32 = $urandom;
                endcase
                put_le(img, word32, width);
            end
            repeat (data_size - frames * frame_bytes) img.push_back(8'($urandom));
        end

        len = img.size();
        if (good && $urandom_range(0, 19) == 0) len = 32'hFFFF_FFFF;
        riff_size = len - RIFF_PREFIX;
        if (roll >= 70 && roll < 76) riff_size ^= 32'd1 << $urandom_range(0, 31);
        for (int i = 0; i < 4; i++) img[4 + i] = riff_size[8*i +: 8];

        keep = img.size();
        if (roll >= 65 && roll < 70) begin
            len  = $urandom_range(0, 36);
            keep = $urandom_range(1, 4);
        end
        if (roll >= 70 && roll < 76) keep = 8 + $urandom_range(0, 2);
        if (roll >= 76 && roll < 91) keep = 36 + $urandom_range(0, 4);
        if (roll >= 91 && roll < 96) keep = $urandom_range(1, img.size() - 1);

        if (len != cur_len || $urandom_range(0, 3) == 0) begin
            settle();
            write_length(len);
        end
        gaps_on = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < keep; i++) send_byte(img[i], i == 0);
        if (good) repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        bytes_sent += keep;
        files_sent++;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.file_start = 1'b0;
        out_ch.ready     = 1'b0;
        typed_pending    = 1'b0;
        typed_word       = '0;
        cur_len          = '0;
        burst_left       = 0;
        gaps_on          = 1'b1;

        // Short files at both length limits, a size mismatch followed by a
        // dropped byte, then a restart in the middle of a valid header.
        dir_rows.push_back('{1'b1, 32'd0,           1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'hAA,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h52,          1'b1, 1'b1, ERR_SHORT});
        dir_rows.push_back('{1'b1, 32'd36,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h52,          1'b1, 1'b1, ERR_SHORT});
        dir_rows.push_back('{1'b1, 32'd37,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h52,          1'b1, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h49,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h1C,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b1, ERR_SIZE});
        dir_rows.push_back('{1'b0, 32'hFF,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b1, 32'hFFFF_FFFF,   1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h52,          1'b1, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h49,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'hF7,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'hFF,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'hFF,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'hFF,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h52,          1'b1, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h49,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h46,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b0, ERR_SHORT});
        dir_rows.push_back('{1'b0, 32'h00,          1'b0, 1'b1, ERR_SIZE});

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                settle();
                write_length(dir_rows[r].value);
            end else begin
                typed_word            = '0;
                typed_word.kind       = KIND_ERROR;
                typed_word.error_code = dir_rows[r].code;
                typed_pending         = dir_rows[r].typed;
                send_byte(dir_rows[r].value[7:0], dir_rows[r].start);
                typed_pending         = 1'b0;
                bytes_sent++;
            end
        end

        while (bytes_sent < BYTE_TARGET) run_file();

        settle();
        if (expected_words.size() != 0)
            report_mismatch("words never delivered", expected_words.size(), '0);
        $display("Sent %0d bytes in %0d random files after the directed table.",
                 bytes_sent, files_sent);
        $display("Checked %0d format reports, %0d samples and %0d errors.",
                 n_reports, n_samples, n_errors);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
